@@ design/fpl_pkg.sv @@
// ----------------------------------------------------------------------------
// fpl_pkg
// Types and fixed constants shared by the frame table.
// ----------------------------------------------------------------------------
`default_nettype none

package fpl_pkg;

  localparam int unsigned INDEX_W = 6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_WRITE
  } state_t;

endpackage

`default_nettype wire

@@ design/fpl_frame_ram.sv @@
// ----------------------------------------------------------------------------
// fpl_frame_ram
// One write port, one read port frame memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpl_frame_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 52,
  localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/fpl_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpl_ctrl
// Scan sequencer: walks the full frames, finds the hit, the oldest stamp and
// the FIFO victim, then writes back the referenced frame.
// ----------------------------------------------------------------------------
`default_nettype none

module fpl_ctrl #(
  parameter int unsigned FRAMES     = 64,
  parameter int unsigned PAGE_BITS  = 20,
  parameter int unsigned STAMP_BITS = 32,
  localparam int unsigned FRAME_BITS = $clog2(FRAMES),
  localparam int unsigned FILL_BITS  = $clog2(FRAMES + 1),
  localparam int unsigned WORD_BITS  = PAGE_BITS + STAMP_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [PAGE_BITS-1:0]        page_number,
  input  wire logic                        replace_mode,
  output logic                             done,
  output logic                             hit,
  output logic      [fpl_pkg::INDEX_W-1:0] frame_index,
  output logic                             evicted,
  output logic      [PAGE_BITS-1:0]        evicted_page,
  output logic                             mem_we,
  output logic      [FRAME_BITS-1:0]       mem_waddr,
  output logic      [WORD_BITS-1:0]        mem_wdata,
  output logic                             mem_re,
  output logic      [FRAME_BITS-1:0]       mem_raddr,
  input  wire logic [WORD_BITS-1:0]        mem_rdata
);

  import fpl_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic [PAGE_BITS-1:0]    page;
  logic [FILL_BITS-1:0]    fill;
  logic [FRAME_BITS-1:0]   fifo_ptr;
  logic [STAMP_BITS-1:0]   access_count;
  logic [FRAME_BITS-1:0]   rd_addr;
  logic                    rd_vld;
  logic [FRAME_BITS-1:0]   rd_idx;
  logic                    hit_found;
  logic [FRAME_BITS-1:0]   hit_idx;
  logic [STAMP_BITS-1:0]   lru_stamp;
  logic [FRAME_BITS-1:0]   lru_idx;
  logic [PAGE_BITS-1:0]    lru_page;
  logic [PAGE_BITS-1:0]    fifo_page;

  logic                    table_full;
  logic                    scan_last;
  logic [FRAME_BITS-1:0]   widx;
  logic                    ev;
  logic [PAGE_BITS-1:0]    evp;
  logic [PAGE_BITS-1:0]    rpage;
  logic [STAMP_BITS-1:0]   rstamp;

  assign table_full = (fill == FILL_BITS'(FRAMES));
  assign scan_last  = ((FILL_BITS'(rd_addr) + FILL_BITS'(1)) == fill);
  assign rpage      = mem_rdata[WORD_BITS-1:STAMP_BITS];
  assign rstamp     = mem_rdata[STAMP_BITS-1:0];

  // victim and target frame
  always_comb begin
    widx = hit_idx;
    ev   = 1'b0;
    evp  = '0;
    if (hit_found) begin
      widx = hit_idx;
    end else if (!table_full) begin
      widx = fill[FRAME_BITS-1:0];
    end else if (!replace_mode) begin
      widx = fifo_ptr;
      ev   = 1'b1;
      evp  = fifo_page;
    end else begin
      widx = lru_idx;
      ev   = 1'b1;
      evp  = lru_page;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (fill == '0) ? S_WRITE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST:  state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != S_IDLE);
    mem_re       = (state == S_SCAN);
    mem_raddr    = rd_addr;
    done         = (state == S_WRITE);
    mem_we       = (state == S_WRITE);
    mem_waddr    = widx;
    mem_wdata    = {page, access_count};
    hit          = hit_found;
    frame_index  = INDEX_W'(widx);
    evicted      = ev;
    evicted_page = evp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      fifo_ptr     <= '0;
      access_count <= '0;
      rd_vld       <= 1'b0;
      hit_found    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN);
      if (state == S_IDLE && start) begin
        hit_found <= 1'b0;
      end else if (rd_vld && !hit_found && rpage == page) begin
        hit_found <= 1'b1;
      end
      if (state == S_WRITE) begin
        if (!hit_found && !table_full) begin
          fill <= fill + FILL_BITS'(1);
        end
        if (ev && !replace_mode) begin
          fifo_ptr <= (fifo_ptr == FRAME_BITS'(FRAMES - 1)) ? '0
                                                           : fifo_ptr + FRAME_BITS'(1);
        end
        if (access_count != '1) begin
          access_count <= access_count + STAMP_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      page    <= page_number;
      rd_addr <= '0;
    end else if (state == S_SCAN) begin
      rd_addr <= rd_addr + FRAME_BITS'(1);
    end
    rd_idx <= rd_addr;
    if (rd_vld) begin
      if (!hit_found && rpage == page) begin
        hit_idx <= rd_idx;
      end
      if (rd_idx == '0 || rstamp < lru_stamp) begin
        lru_stamp <= rstamp;
        lru_idx   <= rd_idx;
        lru_page  <= rpage;
      end
      if (rd_idx == fifo_ptr) begin
        fifo_page <= rpage;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/page_replacement_fifo_lru.sv @@
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru
// Fully associative frame table with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// A reference is taken when start is high and busy is low. The filled
// frames of the frame memory are scanned one entry per cycle through its
// single read port (the scan is skipped when the table is empty), then the
// referenced frame is written back. The result appears for one cycle with
// done high and cannot be stalled. mode_we writes the replacement mode
// (0 FIFO, 1 LRU) and must only be used while busy is low.
`default_nettype none

module page_replacement_fifo_lru #(
  parameter int unsigned FRAMES     = 64,
  parameter int unsigned PAGE_BITS  = 20,
  parameter int unsigned STAMP_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [PAGE_BITS-1:0]        page_number,
  input  wire logic                        mode_we,
  input  wire logic                        mode_wdata,
  output logic                             done,
  output logic                             hit,
  output logic      [fpl_pkg::INDEX_W-1:0] frame_index,
  output logic                             evicted,
  output logic      [PAGE_BITS-1:0]        evicted_page
);

  import fpl_pkg::*;

  localparam int unsigned FRAME_BITS = $clog2(FRAMES);
  localparam int unsigned WORD_BITS  = PAGE_BITS + STAMP_BITS;

  logic                  replace_mode;
  logic                  mem_we;
  logic [FRAME_BITS-1:0] mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic                  mem_re;
  logic [FRAME_BITS-1:0] mem_raddr;
  logic [WORD_BITS-1:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode <= 1'b0;
    end else if (mode_we) begin
      replace_mode <= mode_wdata;
    end
  end

  fpl_frame_ram #(
    .DEPTH (FRAMES),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fpl_ctrl #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .page_number  (page_number),
    .replace_mode (replace_mode),
    .done         (done),
    .hit          (hit),
    .frame_index  (frame_index),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

endmodule

`default_nettype wire

@@ design/fpl_checker.sv @@
// ----------------------------------------------------------------------------
// fpl_checker
// Port-level checks on the frame table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpl_checker #(
  parameter int unsigned PAGE_BITS = 20
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire logic                 hit,
  input wire logic                 evicted,
  input wire logic [PAGE_BITS-1:0] evicted_page
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result word outside busy window");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("busy held after result word");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> !evicted)
    else $error("hit reported with eviction");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    done && !evicted |-> evicted_page == '0)
    else $error("evicted page nonzero without eviction");

endmodule

bind page_replacement_fifo_lru fpl_checker #(.PAGE_BITS(PAGE_BITS)) u_fpl_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .hit          (hit),
  .evicted      (evicted),
  .evicted_page (evicted_page)
);

`default_nettype wire
